@@ rtl/assert_macros.svh @@
// Assertion macros for the stereo tremolo RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/strem_pkg.sv @@
// Types, constants and cosine table builder for the stereo tremolo.
package strem_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int PHASE_BITS     = 32;
    localparam int COS_TABLE_BITS = 10;
    localparam int COS_DEPTH      = 1 << COS_TABLE_BITS;
    localparam int FRAC_BITS      = 16;
    localparam int GAIN_BITS      = FRAC_BITS + 1;
    localparam int DEPTH_BITS     = 17;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [GAIN_BITS-1:0]  ONE_Q16          = GAIN_BITS'(1 << FRAC_BITS);
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET      = DEPTH_BITS'(65536);
    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = PHASE_BITS'(486965);
    localparam logic [63:0]           HALF_PI_Q30      = 64'd1686629713;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } result_t;

    // How the table entry maps onto the signed cosine
    typedef struct packed {
        logic negate;
        logic zero;
    } cos_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MULT
    } state_t;

    typedef logic [GAIN_BITS-1:0] cos_rom_t [COS_DEPTH];

    // Quarter-wave cosine in Q16: Taylor series in Q30, eleven terms, round half up.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      acc;
        for (int k = 0; k < COS_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            v = (64'(acc) + (64'd1 << 13)) >> 14;
            if (v > 64'(ONE_Q16))
                v = 64'(ONE_Q16);
            rom[k] = GAIN_BITS'(v);
        end
        return rom;
    endfunction

endpackage

@@ rtl/strem_cos_rom.sv @@
// Quarter-wave cosine ROM with registered read data.
module strem_cos_rom (
    input  logic                                 clk,
    input  logic [strem_pkg::COS_TABLE_BITS-1:0] addr,
    output logic [strem_pkg::GAIN_BITS-1:0]      data
);
    import strem_pkg::*;

    localparam cos_rom_t COS_ROM = build_cos_rom();

    logic [GAIN_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= COS_ROM[addr];
    end

    assign data = data_reg;

endmodule

@@ rtl/strem_gain.sv @@
// Gain from cosine table entry and depth: 1 - depth * (1 + cos) / 2 in Q16.
module strem_gain (
    input  logic [strem_pkg::GAIN_BITS-1:0]  rom_data,
    input  strem_pkg::cos_sel_t              cos_sel,
    input  logic [strem_pkg::DEPTH_BITS-1:0] depth,
    output logic [strem_pkg::GAIN_BITS-1:0]  gain
);
    import strem_pkg::*;

    logic [GAIN_BITS-1:0]              mag;
    logic [GAIN_BITS:0]                raised;
    logic [GAIN_BITS-1:0]              w;
    logic [DEPTH_BITS-1:0]             depth_sat;
    logic [GAIN_BITS+DEPTH_BITS-1:0]   prod;

    always_comb
    begin
        mag = cos_sel.zero ? '0 : rom_data;
        if (cos_sel.negate)
            raised = {1'b0, ONE_Q16} - {1'b0, mag};
        else
            raised = {1'b0, ONE_Q16} + {1'b0, mag};
        w = raised[GAIN_BITS:1];
        // Saturate depth above full scale
        depth_sat = (depth > DEPTH_BITS'(ONE_Q16)) ? DEPTH_BITS'(ONE_Q16) : depth;
        prod = (GAIN_BITS + DEPTH_BITS)'(depth_sat) * (GAIN_BITS + DEPTH_BITS)'(w);
        gain = ONE_Q16 - prod[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
    end

endmodule

@@ rtl/strem_lane.sv @@
// One channel lane: sample times Q16 gain, floored.
module strem_lane (
    input  logic signed [strem_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic        [strem_pkg::GAIN_BITS-1:0]   gain,
    output logic signed [strem_pkg::SAMPLE_BITS-1:0] sample_out
);
    import strem_pkg::*;

    logic signed [SAMPLE_BITS+GAIN_BITS:0] product;

    assign product    = (SAMPLE_BITS+GAIN_BITS+1)'(sample_in)
                        * (SAMPLE_BITS+GAIN_BITS+1)'($signed({1'b0, gain}));
    assign sample_out = product[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];

endmodule

@@ rtl/stereo_tremolo.sv @@
// Stereo tremolo top level: LFO phase, cosine lookup, gain and two channel lanes.
// Steps: table read at the accepting edge, then gain register, then lane multiply into the result register.
// The three-state sequencer holds one pair at a time until it reaches the result register.
// The result register frees the lanes, so a new pair is taken while a result waits.
// Reset: depth = 1.0, phase step = 486965, LFO phase = 0, no result pending.
module stereo_tremolo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [strem_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [strem_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  strem_pkg::sample_t                   sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output strem_pkg::result_t                   result
);
    import strem_pkg::*;

    `include "assert_macros.svh"

    // Configuration and LFO state
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0] lfo_phase_reg;

    // Sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   load_result;

    // Pair in flight
    sample_t              sample_reg;
    cos_sel_t             cos_sel_reg;
    cos_sel_t             cos_sel_next;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [GAIN_BITS-1:0] gain_next;

    // Table lookup
    logic [1:0]                quadrant;
    logic [COS_TABLE_BITS-1:0] table_index;
    logic [COS_TABLE_BITS-1:0] rom_addr;
    logic [GAIN_BITS-1:0]      rom_data;

    // Lane outputs and result register
    logic signed [SAMPLE_BITS-1:0] left_lane;
    logic signed [SAMPLE_BITS-1:0] right_lane;
    result_t                       result_reg;
    logic                          result_valid_reg;

    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;

    // Quadrant from the top two phase bits, table index from the next bits.
    // Odd quadrants read the mirrored entry Q - i; Q itself means cosine zero.
    assign quadrant    = lfo_phase_reg[PHASE_BITS-1 -: 2];
    assign table_index = lfo_phase_reg[PHASE_BITS-3 -: COS_TABLE_BITS];

    always_comb
    begin
        if (quadrant[0])
            rom_addr = '0 - table_index;
        else
            rom_addr = table_index;
        cos_sel_next.zero   = quadrant[0] && (table_index == '0);
        cos_sel_next.negate = quadrant[0] ^ quadrant[1];
    end

    // The table is always addressed by the current phase; the pair accepted
    // at this edge captures the entry for its own phase.
    strem_cos_rom u_cos_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    strem_gain u_gain (
        .rom_data (rom_data),
        .cos_sel  (cos_sel_reg),
        .depth    (depth_reg),
        .gain     (gain_next)
    );

    // Two lanes share the gain, one per channel
    strem_lane u_lane_left (
        .sample_in  (sample_reg.left_in),
        .gain       (gain_reg),
        .sample_out (left_lane)
    );

    strem_lane u_lane_right (
        .sample_in  (sample_reg.right_in),
        .gain       (gain_reg),
        .sample_out (right_lane)
    );

    // Configuration registers and LFO phase; a phase-step write restarts the LFO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= DEPTH_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
            lfo_phase_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPTH:
                begin
                    depth_reg <= cfg_data[DEPTH_BITS-1:0];
                end
                REG_PHASE_STEP:
                begin
                    phase_step_reg <= cfg_data[PHASE_BITS-1:0];
                    lfo_phase_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            // Advance after the pair's lookup; wrap at a full turn
            lfo_phase_reg <= lfo_phase_reg + phase_step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state: take a pair, compute gain, then drive both lanes into the
    // result register once it is free
    always_comb
    begin
        state_next  = state_reg;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample;
            cos_sel_reg <= cos_sel_next;
        end
        if (state_reg == ST_LOOKUP)
            gain_reg <= gain_next;
        if (load_result)
        begin
            result_reg.left_out  <= left_lane;
            result_reg.right_out <= right_lane;
        end
    end

    // Merge stage: hold the lane pair until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_result)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ST_ASSERT_NEXT(a_accept_starts_lookup, sample_valid && !sample_stall,
                    state_reg == ST_LOOKUP, "accepted pair did not start a lookup")
    `ST_ASSERT_NEXT(a_phase_advance, sample_valid && !sample_stall && !cfg_write,
                    lfo_phase_reg == $past(lfo_phase_reg + phase_step_reg),
                    "LFO phase did not advance by the step")
    `ST_ASSERT_SAME(a_gain_bounded, state_reg == ST_MULT, gain_reg <= ONE_Q16,
                    "gain above unity")
    `ST_ASSERT_SAME(a_result_from_mult, $rose(result_valid), $past(state_reg == ST_MULT),
                    "result appeared without a lane multiply")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the stereo tremolo: random pairs, register sweeps, scoreboard.
module tb;
    import strem_pkg::*;

    // Fixed-point constants of the tremolo, kept apart from the RTL package
    localparam int                SMP_W            = 24;
    localparam int                LUT_BITS         = 10;
    localparam int                LUT_DEPTH        = 1 << LUT_BITS;
    localparam int                LUT_LSB          = 32 - 2 - LUT_BITS;
    localparam longint            UNITY_Q16        = 65536;
    localparam longint unsigned   QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [16:0]       DEPTH_AT_RESET   = 17'd65536;
    localparam logic [31:0]       STEP_AT_RESET    = 32'd486965;
    localparam logic signed [23:0] S_MAX           = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN           = -24'sh800000;
    localparam int                CYCLE_LIMIT      = 400000;

    // Receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_COIN,
        RX_CHOKE,
        RX_PULSE
    } rx_mode_t;

    // Scoreboard: mirrors the registers and the LFO, predicts each shaped pair
    class tremolo_scoreboard;
        logic [16:0] depth_reg;
        logic [31:0] step_reg;
        logic [31:0] lfo_phase;
        logic [16:0] cos_lut [LUT_DEPTH];
        result_t     shaped_pairs [$];
        int          mismatches;
        int          checked;

        // Build the quarter-wave cosine: Q30 Taylor series, rounded to Q16
        function new();
            longint unsigned ang;
            longint unsigned ang_sq;
            longint unsigned term;
            longint unsigned rounded;
            longint          acc;
            for (int k = 0; k < LUT_DEPTH; k++)
            begin
                ang    = (QUARTER_TURN_Q30 * 64'(k)) >> LUT_BITS;
                ang_sq = (ang * ang) >> 30;
                term   = 64'd1 << 30;
                acc    = longint'(term);
                for (int n = 1; n <= 10; n++)
                begin
                    term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                rounded = (64'(acc) + 64'd8192) >> 14;
                if (rounded > 64'd65536)
                    rounded = 64'd65536;
                cos_lut[k] = 17'(rounded);
            end
            depth_reg  = DEPTH_AT_RESET;
            step_reg   = STEP_AT_RESET;
            lfo_phase  = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_DEPTH)
                depth_reg = data[16:0];
            else if (idx == REG_PHASE_STEP)
            begin
                step_reg  = data;
                lfo_phase = '0;
            end
        endfunction

        // Gain from the phase before the advance, then floor(sample * gain / 2^16)
        function result_t shape_pair(sample_t pair);
            int unsigned idx;
            longint      cos_val;
            longint      weight;
            longint      eff_depth;
            longint      gain;
            longint      left_p;
            longint      right_p;
            result_t     shaped;
            idx = 32'(lfo_phase[LUT_LSB +: LUT_BITS]);
            case (lfo_phase[31:30])
                2'd0: cos_val = longint'(cos_lut[idx]);
                2'd1: cos_val = (idx == 0) ? 0 : -longint'(cos_lut[LUT_DEPTH - idx]);
                2'd2: cos_val = -longint'(cos_lut[idx]);
                default: cos_val = (idx == 0) ? 0 : longint'(cos_lut[LUT_DEPTH - idx]);
            endcase
            weight    = (UNITY_Q16 + cos_val) >>> 1;
            eff_depth = (longint'(depth_reg) > UNITY_Q16) ? UNITY_Q16 : longint'(depth_reg);
            gain      = UNITY_Q16 - ((eff_depth * weight) >>> 16);
            left_p    = (longint'($signed(pair.left_in)) * gain) >>> 16;
            right_p   = (longint'($signed(pair.right_in)) * gain) >>> 16;
            shaped.left_out  = left_p[SMP_W-1:0];
            shaped.right_out = right_p[SMP_W-1:0];
            lfo_phase = lfo_phase + step_reg;
            return shaped;
        endfunction

        function void take_pair(sample_t pair);
            shaped_pairs.push_back(shape_pair(pair));
        endfunction

        function void check_pair(result_t got);
            result_t want;
            if (shaped_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d with nothing pending",
                             got.left_out, got.right_out);
                return;
            end
            want = shaped_pairs.pop_front();
            if (got.left_out !== want.left_out || got.right_out !== want.right_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected %0d/%0d, got %0d/%0d", checked,
                             want.left_out, want.right_out, got.left_out, got.right_out);
            end
            checked++;
        endfunction

        function int pending();
            return shaped_pairs.size();
        endfunction

        // Count results that never came as failures too
        function int close_out();
            if (shaped_pairs.size() != 0)
            begin
                $display("%0d expected results never arrived", shaped_pairs.size());
                mismatches += shaped_pairs.size();
            end
            return mismatches;
        endfunction
    endclass

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample       = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;

    tremolo_scoreboard board = new();
    int                cycle_count = 0;
    int                burst_left = 0;
    rx_mode_t          rx_mode = RX_FLOW;
    int                rx_hold = 0;

    stereo_tremolo u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: end the run if the design hangs
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[stereo_tremolo] ERROR");
        $finish;
    end

    // Observe every handshake at the edge; all values read here are the pre-edge ones.
    // Register writes update the mirror, accepted pairs feed the predictor,
    // accepted results are checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                board.set_register(cfg_index, cfg_data);
            if (sample_valid && !sample_stall)
                board.take_pair(sample);
            if (result_valid && !result_stall)
                board.check_pair(result);
        end
    end

    // Receiver: switch at random between back-pressure styles,
    // including long stretches with no stall at all.
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(20, 90);
        end
        else
            rx_hold <= rx_hold - 1;
        case (rx_mode)
            RX_FLOW:  result_stall <= 1'b0;
            RX_COIN:  result_stall <= ($urandom_range(0, 1) == 1);
            RX_CHOKE: result_stall <= ($urandom_range(0, 5) != 0);
            default:  result_stall <= ((cycle_count % 8) < 3);
        endcase
    end

    function automatic sample_t make_pair(logic signed [SMP_W-1:0] left,
                                          logic signed [SMP_W-1:0] right);
        sample_t pair;
        pair.left_in  = left;
        pair.right_in = right;
        return pair;
    endfunction

    // Mostly full-range random samples, now and then an extreme or near-zero value
    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return -24'sd1;
            3:       return 24'sd0;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_depth();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return $urandom;
            3:       return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_step();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return STEP_AT_RESET;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1, 1 << 22);
            4:       return $urandom_range(1 << 24, 1 << 28);
            default: return $urandom;
        endcase
    endfunction

    // Write one register; drop the enable afterwards so it goes low between writes
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pair and hold it until the transaction completes.
    // Bursts of random length, separated by random gaps with valid low.
    task automatic send_pair(input sample_t pair);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap        = $urandom_range(0, 7);
            if (gap != 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= pair;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has been checked,
    // then wait for the pipeline to settle.
    task automatic drain_results();
        sample_valid <= 1'b0;
        burst_left = 0;
        // Let the monitor log the transaction accepted at this edge first
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int pause_at;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: phase zero gives zero gain at full depth
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MIN, S_MAX));
        send_pair(make_pair(24'sd0, -24'sd1));
        send_pair(make_pair(24'sd1, -24'sd1));

        // Zero depth passes samples through untouched
        drain_results();
        write_reg(REG_DEPTH, 32'd0);
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(-24'sd1, 24'sd1));
        send_pair(make_pair(24'sd0, 24'sd0));
        send_pair(make_pair(S_MIN, -24'sd1));

        // Quarter-turn step walks all four quadrants at table index zero
        drain_results();
        write_reg(REG_DEPTH, 32'd65536);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MIN, S_MAX));
        send_pair(make_pair(-24'sd1, -24'sd1));
        send_pair(make_pair(S_MAX, 24'sd1));
        send_pair(make_pair(S_MIN, 24'sd0));

        // Depth above full scale saturates; a step above a half turn wraps backward
        drain_results();
        write_reg(REG_DEPTH, 32'd131071);
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MIN, S_MAX));
        send_pair(make_pair(-24'sd1, 24'sd1));
        send_pair(make_pair(random_sample(), random_sample()));

        // Just over full depth, half-turn step: toggle between zero and unity gain
        drain_results();
        write_reg(REG_DEPTH, 32'd65537);
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MIN, S_MAX));
        send_pair(make_pair(-24'sd1, -24'sd1));

        // Half depth, step that moves the table index every pair
        drain_results();
        write_reg(REG_DEPTH, 32'd32768);
        write_reg(REG_PHASE_STEP, 32'h0010_3039);
        send_pair(make_pair(S_MAX, S_MIN));
        send_pair(make_pair(S_MIN, S_MAX));
        send_pair(make_pair(-24'sd1, 24'sd1));
        send_pair(make_pair(random_sample(), random_sample()));

        // Random phases: settings mostly rewritten between them, one full pause inside each
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            if (ph == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_DEPTH, pick_depth());
            if (ph == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_PHASE_STEP, pick_step());
            pause_at = $urandom_range(10, 110);
            for (int k = 0; k < 125; k++)
            begin
                if (k == pause_at)
                    drain_results();
                send_pair(make_pair(random_sample(), random_sample()));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (board.close_out() == 0)
            $display("[stereo_tremolo] OK");
        else
            $display("[stereo_tremolo] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/strem_pkg.sv
rtl/strem_cos_rom.sv
rtl/strem_gain.sv
rtl/strem_lane.sv
rtl/stereo_tremolo.sv
dv/tb.sv
